@@ src/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the sensor frame deframer
// Phase codes, status codes, register indexes and the result item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam int PayloadMaxDef = 192;
  localparam int HdrLen        = 6;

  localparam int ByteW  = 8;
  localparam int SumW   = 16;
  localparam int CfgIdxW = 2;
  localparam int OutDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegSyncFirst  = 2'd0,
    RegSyncSecond = 2'd1,
    RegFrameType  = 2'd2
  } sfd_reg_e;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'h55;
  localparam logic [ByteW-1:0] FrameTypeRst  = 8'h01;

  typedef enum logic [3:0] {
    PhSync1 = 4'd0,
    PhSync2 = 4'd1,
    PhType  = 4'd2,
    PhId    = 4'd3,
    PhLenLo = 4'd4,
    PhLenHi = 4'd5,
    PhData  = 4'd6,
    PhCkLo  = 4'd7,
    PhCkHi  = 4'd8
  } sfd_phase_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StMismatch = 2'd1,
    StBadLen   = 2'd2
  } sfd_status_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] frame_type;
  } sfd_cfg_t;

  typedef struct packed {
    logic             is_end;
    logic [ByteW-1:0] msg_id;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_index;
    sfd_status_e      status;
    logic [ByteW-1:0] payload_len;
  } sfd_result_t;

endpackage

`default_nettype wire

@@ src/sfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sfd_cfg_regs: configuration registers
// Holds the two sync bytes and the expected type byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [sfd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [sfd_pkg::ByteW-1:0]       cfg_data_i,
  output sfd_pkg::sfd_cfg_t                    cfg_o
);

  sfd_pkg::sfd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        sfd_pkg::RegSyncFirst:  cfg_d.sync_first  = cfg_data_i;
        sfd_pkg::RegSyncSecond: cfg_d.sync_second = cfg_data_i;
        sfd_pkg::RegFrameType:  cfg_d.frame_type  = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= sfd_pkg::SyncFirstRst;
      cfg_q.sync_second <= sfd_pkg::SyncSecondRst;
      cfg_q.frame_type  <= sfd_pkg::FrameTypeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ src/sfd_in_reg.sv @@
// ----------------------------------------------------------------------------
// sfd_in_reg: input register
// Captures one received byte and holds it until the parser steps.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_in_reg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [sfd_pkg::ByteW-1:0]  in_byte_i,
  input  wire logic                       advance_i,
  output      logic                       held_valid_o,
  output      logic [sfd_pkg::ByteW-1:0]  held_byte_o
);

  logic                      valid_q, valid_d;
  logic [sfd_pkg::ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule

`default_nettype wire

@@ src/sfd_parser.sv @@
// ----------------------------------------------------------------------------
// sfd_parser: frame parser
// Header hunt, length check, payload forwarding and 16-bit sum check.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_parser #(
  parameter int PAYLOAD_MAX = sfd_pkg::PayloadMaxDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [sfd_pkg::ByteW-1:0]  byte_i,
  input  wire sfd_pkg::sfd_cfg_t          cfg_i,
  output      logic                       res_valid_o,
  output sfd_pkg::sfd_result_t            res_o
);

  localparam logic [sfd_pkg::SumW-1:0] LenMin = sfd_pkg::SumW'(sfd_pkg::HdrLen);
  localparam logic [sfd_pkg::SumW-1:0] LenMax =
    sfd_pkg::SumW'(sfd_pkg::HdrLen + PAYLOAD_MAX);
  localparam logic [sfd_pkg::ByteW-1:0] HdrLenB = sfd_pkg::ByteW'(sfd_pkg::HdrLen);

  sfd_pkg::sfd_phase_e        phase_q, phase_d;
  logic [sfd_pkg::ByteW-1:0]  id_q, id_d;
  logic [sfd_pkg::ByteW-1:0]  len_lo_q, len_lo_d;
  logic [sfd_pkg::ByteW-1:0]  plen_q, plen_d;
  logic [sfd_pkg::ByteW-1:0]  seen_q, seen_d;
  logic [sfd_pkg::SumW-1:0]   sum_q, sum_d;
  logic [sfd_pkg::ByteW-1:0]  ck_lo_q, ck_lo_d;

  logic [sfd_pkg::SumW-1:0]   sum_add;
  logic [sfd_pkg::SumW-1:0]   total_len;
  logic [sfd_pkg::SumW-1:0]   rx_sum;
  logic [sfd_pkg::ByteW:0]    seen_next;

  assign sum_add   = sum_q + {{(sfd_pkg::SumW-sfd_pkg::ByteW){1'b0}}, byte_i};
  assign total_len = {byte_i, len_lo_q};
  assign rx_sum    = {byte_i, ck_lo_q};
  assign seen_next = {1'b0, seen_q} + (sfd_pkg::ByteW+1)'(1);

  always_comb begin
    phase_d  = phase_q;
    id_d     = id_q;
    len_lo_d = len_lo_q;
    plen_d   = plen_q;
    seen_d   = seen_q;
    sum_d    = sum_q;
    ck_lo_d  = ck_lo_q;

    res_valid_o       = 1'b0;
    res_o.is_end      = 1'b0;
    res_o.msg_id      = id_q;
    res_o.data_byte   = '0;
    res_o.byte_index  = '0;
    res_o.status      = sfd_pkg::StOk;
    res_o.payload_len = plen_q;

    if (step_i) begin
      case (phase_q)
        sfd_pkg::PhSync2: begin
          phase_d = (byte_i == cfg_i.sync_second) ? sfd_pkg::PhType : sfd_pkg::PhSync1;
        end
        sfd_pkg::PhType: begin
          if (byte_i == cfg_i.frame_type) begin
            sum_d   = {{(sfd_pkg::SumW-sfd_pkg::ByteW){1'b0}}, byte_i};
            phase_d = sfd_pkg::PhId;
          end else begin
            phase_d = sfd_pkg::PhSync1;
          end
        end
        sfd_pkg::PhId: begin
          id_d    = byte_i;
          sum_d   = sum_add;
          phase_d = sfd_pkg::PhLenLo;
        end
        sfd_pkg::PhLenLo: begin
          len_lo_d = byte_i;
          sum_d    = sum_add;
          phase_d  = sfd_pkg::PhLenHi;
        end
        sfd_pkg::PhLenHi: begin
          sum_d  = sum_add;
          seen_d = '0;
          if (total_len < LenMin || total_len > LenMax) begin
            phase_d           = sfd_pkg::PhSync1;
            res_valid_o       = 1'b1;
            res_o.is_end      = 1'b1;
            res_o.status      = sfd_pkg::StBadLen;
            res_o.payload_len = '0;
          end else begin
            plen_d  = len_lo_q - HdrLenB;
            phase_d = (total_len == LenMin) ? sfd_pkg::PhCkLo : sfd_pkg::PhData;
          end
        end
        sfd_pkg::PhData: begin
          sum_d            = sum_add;
          seen_d           = seen_next[sfd_pkg::ByteW-1:0];
          res_valid_o      = 1'b1;
          res_o.data_byte  = byte_i;
          res_o.byte_index = seen_q;
          if (seen_next >= {1'b0, plen_q}) begin
            phase_d = sfd_pkg::PhCkLo;
          end
        end
        sfd_pkg::PhCkLo: begin
          ck_lo_d = byte_i;
          phase_d = sfd_pkg::PhCkHi;
        end
        sfd_pkg::PhCkHi: begin
          phase_d      = sfd_pkg::PhSync1;
          res_valid_o  = 1'b1;
          res_o.is_end = 1'b1;
          res_o.status = (rx_sum == sum_q) ? sfd_pkg::StOk : sfd_pkg::StMismatch;
        end
        default: begin
          phase_d = (byte_i == cfg_i.sync_first) ? sfd_pkg::PhSync2 : sfd_pkg::PhSync1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sfd_pkg::PhSync1;
      id_q     <= '0;
      len_lo_q <= '0;
      plen_q   <= '0;
      seen_q   <= '0;
      sum_q    <= '0;
      ck_lo_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      id_q     <= id_d;
      len_lo_q <= len_lo_d;
      plen_q   <= plen_d;
      seen_q   <= seen_d;
      sum_q    <= sum_d;
      ck_lo_q  <= ck_lo_d;
    end
  end

endmodule

`default_nettype wire

@@ src/sfd_out_reg.sv @@
// ----------------------------------------------------------------------------
// sfd_out_reg: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire sfd_pkg::sfd_result_t res_i,
  output      logic                 can_take_o,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output sfd_pkg::sfd_result_t      res_o
);

  logic                 valid_q, valid_d;
  sfd_pkg::sfd_result_t res_q;

  assign can_take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ src/sensor_frame_deframer_sum16_core.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_deframer_sum16_core: length-prefixed frame deframer
// Hunts for sync and type, checks length, forwards payload, checks 16-bit sum.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake            | Content
// s_axis   | in  | tvalid / tready      | tdata[7:0] rx_byte
// m_axis   | out | tvalid / tready      | tdata msg_id, data_byte, byte_index,
//          |     |                      | payload_len; tlast is_end; tuser status
// cfg      | in  | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// One byte per cycle while the result channel takes its items; a result is offered
// from the result register after its byte has passed the input register and parser.
// The parser steps once per byte, set by its phase register and 16-bit sum.
// Reset clears the phase, the sum and all valid flags; registers take defaults.
// A stalled result stalls the parser only while the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_deframer_sum16_core #(
  parameter int PAYLOAD_MAX = sfd_pkg::PayloadMaxDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,  // [7:0] rx_byte
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [7:0] msg_id, [15:8] data_byte, [23:16] byte_index, [31:24] payload_len
  output      logic [sfd_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output      logic                           m_axis_tlast_o,
  output      logic [1:0]                     m_axis_tuser_o,  // [1:0] status
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [sfd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [sfd_pkg::ByteW-1:0]      cfg_data_i
);

  sfd_pkg::sfd_cfg_t    cfg;
  sfd_pkg::sfd_result_t res, out_res;
  logic                 held_valid;
  logic [sfd_pkg::ByteW-1:0] held_byte;
  logic                 res_valid;
  logic                 can_take;
  logic                 advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = held_valid && can_take;

  sfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sfd_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  sfd_parser #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (held_byte),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .can_take_o  (can_take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = {out_res.payload_len, out_res.byte_index,
                           out_res.data_byte, out_res.msg_id};
  assign m_axis_tlast_o = out_res.is_end;
  assign m_axis_tuser_o = out_res.status;

endmodule

`default_nettype wire

@@ src/sfd_checker.sv @@
// ----------------------------------------------------------------------------
// sfd_checker: port-level checks of the deframer
// Watches the result channel for consistent item contents and stall holding.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [sfd_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                         m_axis_tlast_o,
  input wire logic [1:0]                   m_axis_tuser_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("result item changed while stalled");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |->
      m_axis_tuser_o == sfd_pkg::StOk &&
      m_axis_tdata_o[23:16] < m_axis_tdata_o[31:24])
    else $error("payload item with bad status or index");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      m_axis_tdata_o[23:8] == 16'h0000 &&
      (m_axis_tuser_o == sfd_pkg::StOk || m_axis_tuser_o == sfd_pkg::StMismatch ||
       m_axis_tuser_o == sfd_pkg::StBadLen))
    else $error("end item carries data or an unknown status");

  a_badlen_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == sfd_pkg::StBadLen |->
      m_axis_tlast_o && m_axis_tdata_o[31:24] == 8'h00)
    else $error("bad-length report with a payload length");

endmodule

bind sensor_frame_deframer_sum16_core sfd_checker u_sfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
